// File: hdl/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// shared types, constants and helpers of the printf conversion formatter
// ----------------------------------------------------------------------------
package pcf_pkg;

  // stream widths
  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 8;

  // field limit for left_width, zero_width and precision
  localparam logic [4:0] FIELD_WIDTH_MAX = 5'd20;

  // reciprocal of ten, used as floor(v * RECIP10 / 2**35) = v / 10
  localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
  localparam int          RECIP10_SH = 35;

  // ascii codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LOW_X   = 8'h78;
  localparam logic [7:0] CH_UP_X    = 8'h58;

  // conversion kinds
  typedef enum logic [2:0] {
    FN_CHAR    = 3'd0,
    FN_SDEC    = 3'd1,
    FN_UDEC    = 3'd2,
    FN_HEX_LO  = 3'd3,
    FN_HEX_UP  = 3'd4,
    FN_POINTER = 3'd5,
    FN_PERCENT = 3'd6,
    FN_NONE    = 3'd7
  } func_e_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_SUB  = 5'b00100,
    ST_PLAN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  // clamp a width field to the field limit
  function automatic logic [4:0] sat_width(input logic [4:0] w);
    return (w > FIELD_WIDTH_MAX) ? FIELD_WIDTH_MAX : w;
  endfunction

  // digit value to ascii, upper or lower case letters
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else if (upper) begin
      c = 8'h41 + {4'd0, d - 4'd10};
    end else begin
      c = 8'h61 + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// File: hdl/printf_conversion_formatter.sv
// ----------------------------------------------------------------------------
// printf_conversion_formatter
// turns one parsed printf conversion into its ascii characters
// ----------------------------------------------------------------------------
// One input word carries a parsed conversion (kind in in_tuser, value and
// flags in in_tdata); the block answers with its characters on the out
// stream, one character per word, with out_tlast on the final one. A
// conversion that prints nothing (decimal zero with precision zero, or the
// unused kind code) produces no output word at all. Digits come from one
// shared divide step: a decimal digit takes a 32x32 multiply by the
// reciprocal of ten (ST_MUL), then a subtract for the remainder (ST_SUB),
// a hex or pointer digit a shift in ST_SUB alone; a conversion is loaded in
// ST_IDLE, makes its digits, is planned in ST_PLAN and then emits one character per cycle
// while out_tready is high; char and percent skip the digit loop. in_tready
// is high only between conversions. The output word sits in a register, so
// the next conversion may be loaded while the last character still waits.
// ----------------------------------------------------------------------------
module printf_conversion_formatter
  import pcf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // conversion in
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // value[63:0], left_width[68:64], zero_width[73:69], has_precision[74],
  // precision[79:75], alt_form[80], space_sign[81], plus_sign[82]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func[2:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  // characters out
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_char[7:0]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  // input field split
  logic [63:0] in_value;
  logic [4:0]  in_lw, in_zw, in_prec;
  logic        in_hasp, in_alt, in_spc, in_plus;
  func_e_t     in_func;
  logic [31:0] in_v32;

  assign in_value = in_tdata[63:0];
  assign in_lw    = sat_width(in_tdata[68:64]);
  assign in_zw    = sat_width(in_tdata[73:69]);
  assign in_hasp  = in_tdata[74];
  assign in_prec  = sat_width(in_tdata[79:75]);
  assign in_alt   = in_tdata[80];
  assign in_spc   = in_tdata[81];
  assign in_plus  = in_tdata[82];
  assign in_func  = func_e_t'(in_tuser);
  assign in_v32   = in_value[31:0];

  // control state
  state_t      state_r, state_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [6:0]  rem_r, rem_nxt;           // characters still to emit
  logic [1:0]  pre_cnt_r, pre_cnt_nxt;   // sign / 0x / char prefix
  logic [5:0]  zero_cnt_r, zero_cnt_nxt; // both zero paddings together
  logic [4:0]  dig_cnt_r, dig_cnt_nxt;
  logic [4:0]  sp_cnt_r, sp_cnt_nxt;
  logic [4:0]  len_r, len_nxt;           // digits generated so far

  // payload
  logic [63:0] work_r, work_nxt;         // value still to split into digits
  logic [63:0] prod_r, prod_nxt;         // reciprocal product
  logic [63:0] dig_r, dig_nxt;           // digits, most significant at the top
  logic [15:0] pre_r, pre_nxt;           // prefix chars, first at the top
  logic [7:0]  out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;
  logic [4:0]  lw_r, lw_nxt, zw_r, zw_nxt, prec_r, prec_nxt;
  logic        dec_r, dec_nxt;           // base ten, else sixteen
  logic        upper_r, upper_nxt;
  logic        zpad_en_r, zpad_en_nxt;   // zero_width applies
  logic        hasp_en_r, hasp_en_nxt;   // precision applies
  logic        zw_extra_r, zw_extra_nxt; // minus sign eats one zero
  logic [1:0]  sp_extra_r, sp_extra_nxt; // chars counted against left_width

  // divide step
  logic [28:0] q_dec;
  logic [31:0] q_times10;
  logic [63:0] step_q;
  logic [3:0]  step_r;

  // planning
  logic [4:0]  need_z, need_s;
  logic [4:0]  zp1, zp2, sp;
  logic [5:0]  zero_total;
  logic [6:0]  total;

  logic        slot_free;

  always_comb begin
    q_dec     = prod_r[RECIP10_SH +: 29];
    q_times10 = {q_dec, 3'b000} + {2'b00, q_dec, 1'b0};
    if (dec_r) begin
      step_q = {35'd0, q_dec};
      step_r = 4'(work_r[31:0] - q_times10);
    end else begin
      step_q = {4'd0, work_r[63:4]};
      step_r = work_r[3:0];
    end
  end

  always_comb begin
    need_z     = len_r + {4'd0, zw_extra_r};
    need_s     = len_r + {3'd0, sp_extra_r};
    zp1        = (zpad_en_r && zw_r > need_z) ? zw_r - need_z : 5'd0;
    zp2        = (hasp_en_r && prec_r > len_r) ? prec_r - len_r : 5'd0;
    sp         = (lw_r > need_s) ? lw_r - need_s : 5'd0;
    zero_total = {1'b0, zp1} + {1'b0, zp2};
    total      = {5'd0, pre_cnt_r} + {1'b0, zero_total} + {2'b00, len_r} + {2'b00, sp};
  end

  assign slot_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    rem_nxt        = rem_r;
    pre_cnt_nxt    = pre_cnt_r;
    zero_cnt_nxt   = zero_cnt_r;
    dig_cnt_nxt    = dig_cnt_r;
    sp_cnt_nxt     = sp_cnt_r;
    len_nxt        = len_r;
    work_nxt       = work_r;
    prod_nxt       = prod_r;
    dig_nxt        = dig_r;
    pre_nxt        = pre_r;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    lw_nxt         = lw_r;
    zw_nxt         = zw_r;
    prec_nxt       = prec_r;
    dec_nxt        = dec_r;
    upper_nxt      = upper_r;
    zpad_en_nxt    = zpad_en_r;
    hasp_en_nxt    = hasp_en_r;
    zw_extra_nxt   = zw_extra_r;
    sp_extra_nxt   = sp_extra_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          lw_nxt       = in_lw;
          zw_nxt       = in_zw;
          prec_nxt     = in_prec;
          len_nxt      = 5'd0;
          dig_nxt      = 64'd0;
          pre_nxt      = 16'd0;
          pre_cnt_nxt  = 2'd0;
          dec_nxt      = 1'b0;
          upper_nxt    = 1'b0;
          zpad_en_nxt  = 1'b0;
          hasp_en_nxt  = 1'b0;
          zw_extra_nxt = 1'b0;
          sp_extra_nxt = 2'd0;
          work_nxt     = {32'd0, in_v32};
          unique case (in_func)
            FN_CHAR, FN_PERCENT: begin
              pre_nxt      = {(in_func == FN_CHAR) ? in_value[7:0] : CH_PERCENT, 8'd0};
              pre_cnt_nxt  = 2'd1;
              sp_extra_nxt = 2'd1;
              state_nxt    = ST_PLAN;
            end
            FN_POINTER: begin
              pre_nxt      = {CH_ZERO, CH_LOW_X};
              pre_cnt_nxt  = 2'd2;
              sp_extra_nxt = 2'd2;
              work_nxt     = in_value;
              state_nxt    = ST_SUB;
            end
            FN_HEX_LO, FN_HEX_UP: begin
              upper_nxt   = (in_func == FN_HEX_UP);
              zpad_en_nxt = 1'b1;
              hasp_en_nxt = in_hasp;
              if (in_alt && in_v32 != 32'd0) begin
                pre_nxt     = {CH_ZERO, (in_func == FN_HEX_UP) ? CH_UP_X : CH_LOW_X};
                pre_cnt_nxt = 2'd2;
              end
              state_nxt = ST_SUB;
            end
            FN_SDEC, FN_UDEC: begin
              dec_nxt     = 1'b1;
              zpad_en_nxt = 1'b1;
              hasp_en_nxt = in_hasp;
              if (in_func == FN_SDEC && in_v32[31]) begin
                // negative: magnitude, minus counts against both widths
                work_nxt     = {32'd0, 32'd0 - in_v32};
                pre_nxt      = {CH_MINUS, 8'd0};
                pre_cnt_nxt  = 2'd1;
                zw_extra_nxt = 1'b1;
                sp_extra_nxt = 2'd1;
              end else if (in_func == FN_SDEC && in_spc && in_plus) begin
                pre_nxt     = {CH_SPACE, CH_PLUS};
                pre_cnt_nxt = 2'd2;
              end else if (in_func == FN_SDEC && in_spc) begin
                pre_nxt     = {CH_SPACE, 8'd0};
                pre_cnt_nxt = 2'd1;
              end else if (in_plus) begin
                pre_nxt     = {CH_PLUS, 8'd0};
                pre_cnt_nxt = 2'd1;
              end
              // zero with precision zero prints nothing
              if (in_hasp && in_prec == 5'd0 && in_v32 == 32'd0) begin
                state_nxt = ST_IDLE;
              end else begin
                state_nxt = ST_MUL;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_MUL: begin
        prod_nxt  = work_r[31:0] * RECIP10;
        state_nxt = ST_SUB;
      end

      ST_SUB: begin
        dig_nxt  = {step_r, dig_r[63:4]};
        len_nxt  = len_r + 5'd1;
        work_nxt = step_q;
        if (step_q == 64'd0) begin
          state_nxt = ST_PLAN;
        end else if (dec_r) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_SUB;
        end
      end

      ST_PLAN: begin
        zero_cnt_nxt = zero_total;
        dig_cnt_nxt  = len_r;
        sp_cnt_nxt   = sp;
        rem_nxt      = total;
        state_nxt    = (total == 7'd0) ? ST_IDLE : ST_EMIT;
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_last_nxt   = (rem_r == 7'd1);
          rem_nxt        = rem_r - 7'd1;
          if (rem_r == 7'd1) begin
            state_nxt = ST_IDLE;
          end
          priority if (pre_cnt_r != 2'd0) begin
            out_char_nxt = pre_r[15:8];
            pre_nxt      = {pre_r[7:0], 8'd0};
            pre_cnt_nxt  = pre_cnt_r - 2'd1;
          end else if (zero_cnt_r != 6'd0) begin
            out_char_nxt = CH_ZERO;
            zero_cnt_nxt = zero_cnt_r - 6'd1;
          end else if (dig_cnt_r != 5'd0) begin
            out_char_nxt = digit_char(dig_r[63:60], upper_r);
            dig_nxt      = {dig_r[59:0], 4'd0};
            dig_cnt_nxt  = dig_cnt_r - 5'd1;
          end else begin
            out_char_nxt = CH_SPACE;
            sp_cnt_nxt   = sp_cnt_r - 5'd1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      rem_r        <= 7'd0;
      pre_cnt_r    <= 2'd0;
      zero_cnt_r   <= 6'd0;
      dig_cnt_r    <= 5'd0;
      sp_cnt_r     <= 5'd0;
      len_r        <= 5'd0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      rem_r        <= rem_nxt;
      pre_cnt_r    <= pre_cnt_nxt;
      zero_cnt_r   <= zero_cnt_nxt;
      dig_cnt_r    <= dig_cnt_nxt;
      sp_cnt_r     <= sp_cnt_nxt;
      len_r        <= len_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    prod_r     <= prod_nxt;
    dig_r      <= dig_nxt;
    pre_r      <= pre_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    lw_r       <= lw_nxt;
    zw_r       <= zw_nxt;
    prec_r     <= prec_nxt;
    dec_r      <= dec_nxt;
    upper_r    <= upper_nxt;
    zpad_en_r  <= zpad_en_nxt;
    hasp_en_r  <= hasp_en_nxt;
    zw_extra_r <= zw_extra_nxt;
    sp_extra_r <= sp_extra_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule
